### hdl/ssu_pkg.sv
package ssu_pkg;

    // default number of hole cells
    localparam int MaxHolesDefault = 16;

    // configuration reset values
    localparam logic        SackEnabledReset = 1'b1;
    localparam logic [15:0] MssReset         = 16'd536;
    localparam logic [7:0]  DupThreshReset   = 8'd3;

    // result status codes
    typedef enum logic [3:0] {
        STAT_APPLIED     = 4'd0,
        STAT_DISABLED    = 4'd1,
        STAT_NO_ACK      = 4'd2,
        STAT_ACK_RANGE   = 4'd3,
        STAT_LENGTH      = 4'd4,
        STAT_INVERTED    = 4'd5,
        STAT_OLD         = 4'd6,
        STAT_BELOW_ACK   = 4'd7,
        STAT_BEYOND_SENT = 4'd8,
        STAT_FULL        = 4'd9,
        STAT_SKIPPED     = 4'd10
    } status_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SACK_ENABLED = 2'd0,
        CFG_MSS          = 2'd1,
        CFG_DUP_THRESH   = 2'd2
    } cfg_index_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_DIV,
        S_WALK,
        S_APPEND,
        S_FINISH
    } state_t;

    // one hole of the scoreboard
    typedef struct packed {
        logic [31:0] start;
        logic [31:0] stop;
        logic [31:0] rtx;
        logic [7:0]  dups;
    } hole_t;

    // command broadcast along the row of cells
    typedef struct packed {
        logic shift;
        logic insert;
    } chain_cmd_t;

    // modulo 2^32 sequence compare
    function automatic logic seq_lt(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] diff;
        diff = a - b;
        return diff[31];
    endfunction

endpackage

### hdl/ssu_cell.sv
module ssu_cell #(
    parameter int MAX_HOLES = ssu_pkg::MaxHolesDefault,
    parameter int IDX       = 0
) (
    input  logic                              aclk,
    input  ssu_pkg::chain_cmd_t               cmd,
    input  logic [$clog2(MAX_HOLES+1)-1:0]    pos,
    input  ssu_pkg::hole_t                    right_in,
    input  ssu_pkg::hole_t                    inject,
    output ssu_pkg::hole_t                    hole_out
);
    import ssu_pkg::*;

    localparam int CW = $clog2(MAX_HOLES + 1);
    localparam logic [CW-1:0] MyPos = CW'(IDX);

    hole_t hole_reg;
    hole_t hole_next;

    // take the injected hole at the tail, else move one place towards the head
    always_comb begin
        hole_next = hole_reg;
        if (cmd.insert && pos == MyPos) begin
            hole_next = inject;
        end else if (cmd.shift && MyPos < pos) begin
            hole_next = right_in;
        end
    end

    always_ff @(posedge aclk) begin
        hole_reg <= hole_next;
    end

    assign hole_out = hole_reg;

endmodule

### hdl/ssu_div.sv
module ssu_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        busy,
    output logic [7:0]  quotient
);
    import ssu_pkg::*;

    logic [31:0] rem_reg, rem_next;
    logic [7:0]  quo_reg, quo_next;
    logic [2:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic [31:0] trial;

    // restoring division, one quotient bit a cycle from the top bit down
    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        trial     = 32'(divisor) << step_reg;
        if (start) begin
            rem_next  = dividend;
            quo_next  = '0;
            step_next = 3'd7;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_reg >= trial) begin
                rem_next           = rem_reg - trial;
                quo_next[step_reg] = 1'b1;
            end
            if (step_reg == 3'd0) begin
                busy_next = 1'b0;
            end else begin
                step_next = step_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

### hdl/sack_scoreboard_update_top.sv
// SACK scoreboard: each request carries one SACK block with its segment's ack fields and
// sender window edges, and returns one result with a status, the hole count, the lowest
// hole and the highest SACKed edge. Holes live in a row of cells kept in sequence order;
// the walk pops the head hole once a cycle, except while it inserts the upper part of a
// split, and pushes its trimmed, bumped or split parts to the tail. A request that fails
// its checks goes from check straight to result. An applied one passes through check,
// multiply, the duplicate-estimate divider, one walk step per hole and per split plus
// one, append and result; on an empty table it skips the walk and append. A block splits
// at most one hole. A new request is taken only once the previous one has reached its
// result register.
module sack_scoreboard_update_top #(
    parameter int MAX_HOLES = ssu_pkg::MaxHolesDefault
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_wdata,
    // request side
    input  logic         s_tvalid,
    output logic         s_tready,
    // ack_flag, segment_ack, oldest_unacked, highest_sent, option_length,
    // block_start, block_end, zero pad
    input  logic [167:0] s_tdata,
    input  logic         s_tlast,
    // result side
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, hole_count, first_hole_start, first_hole_end,
    // first_hole_retransmit, first_hole_dups, last_sacked_end, zero pad
    output logic [151:0] m_tdata
);
    import ssu_pkg::*;

    localparam int CW = $clog2(MAX_HOLES + 1);
    localparam logic [CW-1:0] MaxCount = CW'(MAX_HOLES);

    // configuration registers
    logic        sack_en_reg;
    logic [15:0] mss_reg;
    logic [7:0]  thresh_reg;

    // request registers
    logic        ackf_reg, ackf_next;
    logic [31:0] ack_reg, ack_next;
    logic [31:0] una_reg, una_next;
    logic [31:0] smax_reg, smax_next;
    logic [5:0]  olen_reg, olen_next;
    logic [31:0] bs_reg, bs_next;
    logic [31:0] be_reg, be_next;
    logic        last_reg, last_next;

    // control state
    state_t      state_reg, state_next;
    status_t     status_reg, status_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] unproc_reg, unproc_next;
    logic        stop_reg, stop_next;
    logic        pend_valid_reg, pend_valid_next;
    hole_t       pend_reg, pend_next;
    logic [31:0] edge_reg, edge_next;
    logic        aborted_reg, aborted_next;
    logic [23:0] prod_reg, prod_next;

    // result register
    logic         m_valid_reg, m_valid_next;
    logic [151:0] m_data_reg, m_data_next;

    // row of cells
    hole_t       cell_q [MAX_HOLES];
    chain_cmd_t  cmd;
    logic [CW-1:0] pos;
    hole_t       inject;

    // divider
    logic        div_start;
    logic        div_busy;
    logic [7:0]  div_q;

    logic        out_free;
    hole_t       head;
    logic [31:0] dist_blk;
    logic [7:0]  new_dups;
    logic [7:0]  dup_est;
    logic [15:0] mss_eff;
    status_t     check_st;
    logic [5:0]  olen_m2;
    hole_t       first_hole;

    // hole cells
    for (genvar g = 0; g < MAX_HOLES; g++) begin : g_cell
        hole_t right;
        if (g == MAX_HOLES - 1) begin : g_tail
            assign right = cell_q[g];
        end else begin : g_mid
            assign right = cell_q[g+1];
        end
        ssu_cell #(.MAX_HOLES(MAX_HOLES), .IDX(g)) u_cell (
            .aclk     (aclk),
            .cmd      (cmd),
            .pos      (pos),
            .right_in (right),
            .inject   (inject),
            .hole_out (cell_q[g])
        );
    end

    ssu_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dist_blk),
        .divisor  (mss_eff),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign head     = cell_q[0];
    assign dist_blk = be_reg - bs_reg;
    assign mss_eff  = (mss_reg == 16'd0) ? 16'd1 : mss_reg;
    assign olen_m2  = olen_reg - 6'd2;

    // duplicate estimate for a new hole, clamped to the threshold and at least one
    always_comb begin
        dup_est  = (dist_blk >= 32'(prod_reg)) ? thresh_reg : div_q;
        new_dups = (dup_est == 8'd0) ? 8'd1 : dup_est;
    end

    // bump of a hole's duplicate count for a given distance
    function automatic logic [7:0] bump(input logic [7:0] cnt, input logic [31:0] gap,
                                        input logic [23:0] prod, input logic [7:0] thr);
        logic [7:0] c;
        c = (cnt == 8'hFF) ? cnt : cnt + 8'd1;
        if (gap >= 32'(prod)) begin
            c = thr;
        end
        return c;
    endfunction

    // request checks in priority order
    always_comb begin
        if (aborted_reg) begin
            check_st = STAT_SKIPPED;
        end else if (!sack_en_reg) begin
            check_st = STAT_DISABLED;
        end else if (!ackf_reg) begin
            check_st = STAT_NO_ACK;
        end else if (seq_lt(ack_reg, una_reg) || seq_lt(smax_reg, ack_reg)) begin
            check_st = STAT_ACK_RANGE;
        end else if (olen_reg <= 6'd2 || olen_m2[2:0] != 3'd0) begin
            check_st = STAT_LENGTH;
        end else if (be_reg == bs_reg || seq_lt(be_reg, bs_reg)) begin
            check_st = STAT_INVERTED;
        end else if (be_reg == una_reg || seq_lt(be_reg, una_reg)) begin
            check_st = STAT_OLD;
        end else if (seq_lt(una_reg, ack_reg) && seq_lt(bs_reg, ack_reg)) begin
            check_st = STAT_BELOW_ACK;
        end else if (seq_lt(smax_reg, be_reg)) begin
            check_st = STAT_BEYOND_SENT;
        end else begin
            check_st = STAT_APPLIED;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_CHECK;
            end
            S_CHECK: begin
                state_next = (check_st == STAT_APPLIED) ? S_MUL : S_FINISH;
            end
            S_MUL: begin
                state_next = S_DIV;
            end
            S_DIV: begin
                if (!div_busy) state_next = (count_reg == '0) ? S_FINISH : S_WALK;
            end
            S_WALK: begin
                if (!pend_valid_reg && unproc_reg == '0) state_next = S_APPEND;
            end
            S_APPEND: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and cell commands
    always_comb begin
        ackf_next       = ackf_reg;
        ack_next        = ack_reg;
        una_next        = una_reg;
        smax_next       = smax_reg;
        olen_next       = olen_reg;
        bs_next         = bs_reg;
        be_next         = be_reg;
        last_next       = last_reg;
        status_next     = status_reg;
        count_next      = count_reg;
        unproc_next     = unproc_reg;
        stop_next       = stop_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        edge_next       = edge_reg;
        aborted_next    = aborted_reg;
        prod_next       = prod_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        cmd             = '0;
        pos             = count_reg;
        inject          = pend_reg;
        div_start       = 1'b0;
        first_hole      = (count_reg != '0) ? head : '0;

        unique case (state_reg)
            S_IDLE: begin
                // capture the request
                if (s_tvalid) begin
                    ackf_next = s_tdata[0];
                    ack_next  = s_tdata[32:1];
                    una_next  = s_tdata[64:33];
                    smax_next = s_tdata[96:65];
                    olen_next = s_tdata[102:97];
                    bs_next   = s_tdata[134:103];
                    be_next   = s_tdata[166:135];
                    last_next = s_tlast;
                end
            end
            S_CHECK: begin
                status_next = check_st;
            end
            S_MUL: begin
                // threshold times segment size, for clamp compares
                prod_next = 24'(thresh_reg) * 24'(mss_eff);
                div_start = 1'b1;
            end
            S_DIV: begin
                if (!div_busy) begin
                    if (count_reg == '0) begin
                        // empty table starts a first hole below the block
                        cmd.insert = 1'b1;
                        pos        = '0;
                        inject     = '{start: ack_reg, stop: bs_reg, rtx: ack_reg,
                                       dups: new_dups};
                        count_next = CW'(1);
                        edge_next  = be_reg;
                    end else begin
                        unproc_next     = count_reg;
                        stop_next       = 1'b0;
                        pend_valid_next = 1'b0;
                    end
                end
            end
            S_WALK: begin
                if (pend_valid_reg) begin
                    // upper part of a split goes in behind
                    cmd.insert      = 1'b1;
                    pos             = count_reg;
                    inject          = pend_reg;
                    count_next      = count_reg + CW'(1);
                    pend_valid_next = 1'b0;
                end else if (unproc_reg != '0) begin
                    cmd.shift   = 1'b1;
                    cmd.insert  = 1'b1;
                    pos         = count_reg - CW'(1);
                    inject      = head;
                    unproc_next = unproc_reg - CW'(1);
                    if (stop_reg) begin
                        inject = head;
                    end else if (be_reg == head.start || seq_lt(be_reg, head.start)) begin
                        // block lies below this hole, the rest pass unchanged
                        stop_next = 1'b1;
                    end else if (bs_reg == head.stop || seq_lt(head.stop, bs_reg)) begin
                        // block above the hole
                        inject.dups = bump(head.dups, be_reg - head.stop, prod_reg,
                                           thresh_reg);
                    end else if (bs_reg == head.start || seq_lt(bs_reg, head.start)) begin
                        if (be_reg == head.stop || seq_lt(head.stop, be_reg)) begin
                            // hole fully covered: drop it
                            cmd.insert = 1'b0;
                            count_next = count_reg - CW'(1);
                        end else begin
                            // trim the lower edge
                            inject.start = be_reg;
                            inject.rtx   = seq_lt(head.rtx, be_reg) ? be_reg : head.rtx;
                        end
                    end else if (be_reg == head.stop || seq_lt(head.stop, be_reg)) begin
                        // trim the upper edge
                        inject.stop = bs_reg;
                        inject.rtx  = seq_lt(bs_reg, head.rtx) ? bs_reg : head.rtx;
                        inject.dups = bump(head.dups, dist_blk, prod_reg, thresh_reg);
                    end else if (seq_lt(head.start, bs_reg) && seq_lt(be_reg, head.stop)) begin
                        if (count_reg >= MaxCount) begin
                            // no room to split
                            status_next = STAT_FULL;
                            stop_next   = 1'b1;
                        end else begin
                            inject.stop     = bs_reg;
                            inject.rtx      = seq_lt(bs_reg, head.rtx) ? bs_reg : head.rtx;
                            inject.dups     = bump(head.dups, dist_blk, prod_reg,
                                                   thresh_reg);
                            pend_next       = '{start: be_reg, stop: head.stop,
                                                rtx: seq_lt(head.rtx, be_reg) ? be_reg
                                                                              : head.rtx,
                                                dups: head.dups};
                            pend_valid_next = 1'b1;
                        end
                    end
                end
            end
            S_APPEND: begin
                // new hole between the last SACKed edge and this block
                if (status_reg != STAT_FULL && seq_lt(edge_reg, bs_reg)) begin
                    if (count_reg >= MaxCount) begin
                        status_next = STAT_FULL;
                    end else begin
                        cmd.insert = 1'b1;
                        pos        = count_reg;
                        inject     = '{start: edge_reg, stop: bs_reg, rtx: edge_reg,
                                       dups: new_dups};
                        edge_next  = be_reg;
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'd0, edge_reg, first_hole.dups, first_hole.rtx,
                                    first_hole.stop, first_hole.start,
                                    5'(count_reg), status_reg};
                    if (last_reg) begin
                        aborted_next = 1'b0;
                    end else if (status_reg == STAT_FULL) begin
                        aborted_next = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            edge_reg       <= '0;
            aborted_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            sack_en_reg    <= SackEnabledReset;
            mss_reg        <= MssReset;
            thresh_reg     <= DupThreshReset;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            edge_reg       <= edge_next;
            aborted_reg    <= aborted_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_SACK_ENABLED: sack_en_reg <= cfg_wdata[0];
                    CFG_MSS:          mss_reg     <= cfg_wdata;
                    CFG_DUP_THRESH:   thresh_reg  <= cfg_wdata[7:0];
                    default: begin
                    end
                endcase
            end
        end
        ackf_reg   <= ackf_next;
        ack_reg    <= ack_next;
        una_reg    <= una_next;
        smax_reg   <= smax_next;
        olen_reg   <= olen_next;
        bs_reg     <= bs_next;
        be_reg     <= be_next;
        last_reg   <= last_next;
        status_reg <= status_next;
        unproc_reg <= unproc_next;
        stop_reg   <= stop_next;
        pend_reg   <= pend_next;
        prod_reg   <= prod_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // table never holds more holes than cells
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MaxCount)
        else $error("hole count beyond table size");

    // a pending split half exists only during the walk
    a_pend_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> state_reg == S_WALK)
        else $error("pending hole outside walk");

    // holes still to walk never exceed the table
    a_unproc: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WALK |-> unproc_reg <= count_reg)
        else $error("walk count beyond hole count");

    // an accepted request leaves idle
    a_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == S_CHECK)
        else $error("request not taken into check");

endmodule
